// File: hdl/max_pooling_2d_window_top_macros.svh
// ---------------------------------------------------------------------------
// Max pooling window - assertion macros
// Concurrent check wrappers, compiled out when NO_ASSERTIONS is defined.
// ---------------------------------------------------------------------------
`ifndef MAX_POOLING_2D_WINDOW_TOP_MACROS_SVH
`define MAX_POOLING_2D_WINDOW_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// check under reset qualification
`define MP2D_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// check that also holds during reset
`define MP2D_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);
`else
`define MP2D_ASSERT(lbl, prop, msg)
`define MP2D_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: hdl/mp2d_pkg.sv
// ---------------------------------------------------------------------------
// Max pooling window - package
// Sizes, register indexes, shared types and window span helpers.
// ---------------------------------------------------------------------------
package mp2d_pkg;

   localparam int MAX_HEIGHT  = 256;
   localparam int MAX_WIDTH   = 256;
   localparam int MAX_KERNEL  = 8;
   localparam int SAMPLE_BITS = 16;
   localparam int MAX_RESULTS = 64;

   localparam int KROW_BITS   = $clog2(MAX_KERNEL);
   localparam int COL_BITS    = $clog2(MAX_WIDTH);
   localparam int ADDR_BITS   = KROW_BITS + COL_BITS;
   localparam int STORE_DEPTH = MAX_KERNEL * MAX_WIDTH;

   localparam logic [3:0] REG_IMAGE_HEIGHT  = 4'd0;
   localparam logic [3:0] REG_IMAGE_WIDTH   = 4'd1;
   localparam logic [3:0] REG_WINDOW_HEIGHT = 4'd2;
   localparam logic [3:0] REG_WINDOW_WIDTH  = 4'd3;
   localparam logic [3:0] REG_STEP_ROWS     = 4'd4;
   localparam logic [3:0] REG_STEP_COLS     = 4'd5;
   localparam logic [3:0] REG_BORDER_ROWS   = 4'd6;
   localparam logic [3:0] REG_BORDER_COLS   = 4'd7;

   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN =
      {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   typedef logic signed [13:0] pos_type;

   typedef struct packed {
      logic [8:0] eff_h;
      logic [8:0] eff_w;
      logic [3:0] kh;
      logic [3:0] kw;
      logic [3:0] sh;
      logic [3:0] sw;
      logic [2:0] ph;
      logic [2:0] pw;
      logic [8:0] out_h;
      logic [8:0] out_w;
      logic       busy;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_ROW, ST_COL, ST_SCAN, ST_DRAIN, ST_EMIT,
      ST_FLUSH, ST_ADVW, ST_ADVH, ST_NEXT
   } eng_state_type;

   typedef enum logic {
      CS_IDLE, CS_CALC
   } cfg_state_type;

   // end of clipped window span (exclusive)
   function automatic pos_type win_hi(pos_type st, logic [3:0] k, logic [8:0] n);
      pos_type e;
      pos_type nn;
      e  = st + $signed({10'b0, k});
      nn = $signed({5'b0, n});
      return (e > nn) ? nn : e;
   endfunction

   function automatic pos_type win_lo(pos_type st);
      return (st < 0) ? pos_type'(0) : st;
   endfunction

   // last covered position, clamped into the image
   function automatic logic [7:0] win_trig(pos_type st, logic [3:0] k, logic [8:0] n);
      pos_type t;
      t = win_hi(st, k, n) - pos_type'(1);
      return (t < 0) ? 8'd0 : t[7:0];
   endfunction

endpackage

// File: hdl/max_pooling_2d_window_top.sv
// ---------------------------------------------------------------------------
// Max pooling window - top level
// Streaming 2-D max pooling over raster-order image planes.
// ---------------------------------------------------------------------------
// Usage:
//  - req_*: one pixel per request; req_final_sample marks the last pixel of
//    the tensor. Taken when req_valid is high and req_stall low.
//  - rsp_*: zero or more pooled windows per request, in pooled row then column
//    order; rsp_run_last flags the last one of a request. Taken when
//    rsp_valid is high and rsp_stall low.
//  - csr_*: register writes (index, data), taken when csr_valid and csr_ready
//    are high. A write resizes the pooled plane and restarts at pixel (0,0).
// Sequence:
//  - Each pixel runs the window finder and the pointer walk, also when it
//    completes no window; a row end adds the row pointer advance.
//  - Each window is scanned one covered pixel at a time (up to 64 for 8x8):
//    one read port, one comparator. A window wholly in padding is skipped.
//  - Each result leaves once the next one of the request is ready; the last
//    one leaves when the request is flushed.
// Reset and stall:
//  - After reset and each register write the plane is resized with a shared
//    adder, one stride per cycle, with req_stall high.
//    The line store is not cleared.
//  - A stalled result waits in the output register; one more result is held
//    inside, after that the engine pauses.
// ---------------------------------------------------------------------------
module max_pooling_2d_window_top import mp2d_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                          req_final_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_pooled_value,
   output logic [8:0]                    rsp_pooled_row,
   output logic [8:0]                    rsp_pooled_col,
   output logic                          rsp_run_last,
   output logic                          rsp_plane_last,
   output logic                          rsp_tensor_last,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [3:0]                    csr_index,
   input  logic [8:0]                    csr_wdata
);

   cfg_type cfg;

   logic                          wr_en, rd_en;
   logic [ADDR_BITS-1:0]          wr_addr, rd_addr;
   logic signed [SAMPLE_BITS-1:0] rd_data;

   // registers and pooled plane size
   mp2d_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // last kernel rows, written with each request pixel
   mp2d_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_sample),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // window finder, scan sequencer and result registers
   mp2d_engine u_engine (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_final_sample (req_final_sample),
      .wr_en            (wr_en),
      .wr_addr          (wr_addr),
      .rd_en            (rd_en),
      .rd_addr          (rd_addr),
      .rd_data          (rd_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pooled_value (rsp_pooled_value),
      .rsp_pooled_row   (rsp_pooled_row),
      .rsp_pooled_col   (rsp_pooled_col),
      .rsp_run_last     (rsp_run_last),
      .rsp_plane_last   (rsp_plane_last),
      .rsp_tensor_last  (rsp_tensor_last)
   );

endmodule

// File: hdl/mp2d_cfg.sv
// ---------------------------------------------------------------------------
// Max pooling window - register file
// Holds the setup registers and sizes the pooled plane with a shared adder.
// ---------------------------------------------------------------------------
module mp2d_cfg import mp2d_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [3:0] csr_index,
   input  logic [8:0] csr_wdata,
   output cfg_type    cfg
);

   logic [8:0] ih_ff, iw_ff;
   logic [3:0] kh_ff, kw_ff, sh_ff, sw_ff;
   logic [2:0] bh_ff, bw_ff;
   logic [8:0] oh_ff, ow_ff;
   logic       sel_ff;
   logic [9:0] acc_ff;
   logic [8:0] q_ff;
   cfg_state_type state_ff, state_in;

   logic       wr_known;
   logic [8:0] eh, ew;
   logic [3:0] ekh, ekw, esh, esw;
   logic [8:0] n;
   logic [3:0] k, s;
   logic [2:0] p;
   logic signed [10:0] num;
   logic       finish, anypad;
   logic [8:0] len;

   assign csr_ready = 1'b1;
   assign wr_known  = csr_valid && (csr_index <= REG_BORDER_COLS);

   always_comb begin
      eh  = (ih_ff == 9'd0) ? 9'd1 : ((ih_ff > 9'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : ih_ff);
      ew  = (iw_ff == 9'd0) ? 9'd1 : ((iw_ff > 9'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : iw_ff);
      ekh = (kh_ff == 4'd0) ? 4'd1 : ((kh_ff > 4'(MAX_KERNEL)) ? 4'(MAX_KERNEL) : kh_ff);
      ekw = (kw_ff == 4'd0) ? 4'd1 : ((kw_ff > 4'(MAX_KERNEL)) ? 4'(MAX_KERNEL) : kw_ff);
      esh = (sh_ff == 4'd0) ? 4'd1 : sh_ff;
      esw = (sw_ff == 4'd0) ? 4'd1 : sw_ff;
   end

   // shared sizing unit: one dimension at a time
   always_comb begin
      n      = sel_ff ? ew : eh;
      k      = sel_ff ? ekw : ekh;
      s      = sel_ff ? esw : esh;
      p      = sel_ff ? bw_ff : bh_ff;
      anypad = (bh_ff != 3'd0) || (bw_ff != 3'd0);
      num    = $signed({2'b0, n}) + $signed({7'b0, p, 1'b0}) - $signed({7'b0, k});
      finish = (num < 0) || ($signed({1'b0, acc_ff}) >= num);
      if (num < 0) begin
         len = ((-num) < $signed({7'b0, s})) ? 9'd1 : 9'd0;
      end else if (anypad && (acc_ff >= ({1'b0, n} + {7'b0, p}))) begin
         len = q_ff;
      end else begin
         len = q_ff + 9'd1;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CS_IDLE: if (wr_known) state_in = CS_CALC;
         CS_CALC: if (!wr_known && finish && sel_ff) state_in = CS_IDLE;
         default: state_in = CS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_CALC;
         ih_ff <= 9'd8;  iw_ff <= 9'd8;
         kh_ff <= 4'd2;  kw_ff <= 4'd2;
         sh_ff <= 4'd2;  sw_ff <= 4'd2;
         bh_ff <= 3'd0;  bw_ff <= 3'd0;
         sel_ff <= 1'b0; acc_ff <= '0; q_ff <= '0;
         oh_ff <= '0;    ow_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (wr_known) begin
            unique case (csr_index)
               REG_IMAGE_HEIGHT:  ih_ff <= csr_wdata;
               REG_IMAGE_WIDTH:   iw_ff <= csr_wdata;
               REG_WINDOW_HEIGHT: kh_ff <= csr_wdata[3:0];
               REG_WINDOW_WIDTH:  kw_ff <= csr_wdata[3:0];
               REG_STEP_ROWS:     sh_ff <= csr_wdata[3:0];
               REG_STEP_COLS:     sw_ff <= csr_wdata[3:0];
               REG_BORDER_ROWS:   bh_ff <= csr_wdata[2:0];
               REG_BORDER_COLS:   bw_ff <= csr_wdata[2:0];
               default: ;
            endcase
            sel_ff <= 1'b0;
            acc_ff <= '0;
            q_ff   <= '0;
         end else if (state_ff == CS_CALC) begin
            if (finish) begin
               if (sel_ff) ow_ff <= len;
               else        oh_ff <= len;
               sel_ff <= 1'b1;
               acc_ff <= '0;
               q_ff   <= '0;
            end else begin
               acc_ff <= acc_ff + {6'b0, s};
               q_ff   <= q_ff + 9'd1;
            end
         end
      end
   end

   always_comb begin
      cfg.eff_h = eh;   cfg.eff_w = ew;
      cfg.kh    = ekh;  cfg.kw    = ekw;
      cfg.sh    = esh;  cfg.sw    = esw;
      cfg.ph    = bh_ff; cfg.pw   = bw_ff;
      cfg.out_h = oh_ff; cfg.out_w = ow_ff;
      cfg.busy  = (state_ff == CS_CALC);
   end

endmodule

// File: hdl/mp2d_store.sv
// ---------------------------------------------------------------------------
// Max pooling window - line store
// Last kernel rows of the plane, one write and one registered read port.
// ---------------------------------------------------------------------------
module mp2d_store import mp2d_pkg::*; (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [ADDR_BITS-1:0]          wr_addr,
   input  logic signed [SAMPLE_BITS-1:0] wr_data,
   input  logic                          rd_en,
   input  logic [ADDR_BITS-1:0]          rd_addr,
   output logic signed [SAMPLE_BITS-1:0] rd_data
);

   logic signed [SAMPLE_BITS-1:0] mem [STORE_DEPTH];
   logic signed [SAMPLE_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/mp2d_engine.sv
// ---------------------------------------------------------------------------
// Max pooling window - window engine
// Finds the windows a pixel completes and scans each with one comparator.
// ---------------------------------------------------------------------------
`include "max_pooling_2d_window_top_macros.svh"
module mp2d_engine import mp2d_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  cfg_type                       cfg,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_final_sample,
   output logic                          wr_en,
   output logic [ADDR_BITS-1:0]          wr_addr,
   output logic                          rd_en,
   output logic [ADDR_BITS-1:0]          rd_addr,
   input  logic signed [SAMPLE_BITS-1:0] rd_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_pooled_value,
   output logic [8:0]                    rsp_pooled_row,
   output logic [8:0]                    rsp_pooled_col,
   output logic                          rsp_run_last,
   output logic                          rsp_plane_last,
   output logic                          rsp_tensor_last
);

   eng_state_type state_ff, state_in;

   logic [7:0] r_ff, c_ff, y_ff, x_ff;
   logic [8:0] ph_base_ff, pw_base_ff, ph_ff, pw_ff;
   pos_type    sth_base_ff, stw_base_ff, sth_ff, stw_ff;
   logic [6:0] cnt_ff;
   logic signed [SAMPLE_BITS-1:0] best_ff;
   logic       fin_ff, rd_vld_ff;

   logic       pend_ff, pend_pl_ff, pend_tl_ff;
   logic signed [SAMPLE_BITS-1:0] pend_val_ff;
   logic [8:0] pend_row_ff, pend_col_ff;

   logic       out_vld_ff, out_last_ff, out_pl_ff, out_tl_ff;
   logic signed [SAMPLE_BITS-1:0] out_val_ff;
   logic [8:0] out_row_ff, out_col_ff;

   // shared trigger unit
   pos_type    t_st;
   logic [3:0] t_k;
   logic [8:0] t_n, t_idx, t_len;
   logic [7:0] t_pos;
   logic       cand;

   pos_type    hlo, hhi, wlo, whi;
   logic       win_empty, scan_row_end, scan_end;
   logic       slot_free, accept, row_end, plane_end;
   logic       new_pl;

   always_comb begin
      case (state_ff)
         ST_COL: begin
            t_st = stw_ff; t_k = cfg.kw; t_n = cfg.eff_w; t_pos = c_ff;
            t_idx = pw_ff; t_len = cfg.out_w;
         end
         ST_ADVW: begin
            t_st = stw_base_ff; t_k = cfg.kw; t_n = cfg.eff_w; t_pos = c_ff;
            t_idx = pw_base_ff; t_len = cfg.out_w;
         end
         ST_ADVH: begin
            t_st = sth_base_ff; t_k = cfg.kh; t_n = cfg.eff_h; t_pos = r_ff;
            t_idx = ph_base_ff; t_len = cfg.out_h;
         end
         default: begin
            t_st = sth_ff; t_k = cfg.kh; t_n = cfg.eff_h; t_pos = r_ff;
            t_idx = ph_ff; t_len = cfg.out_h;
         end
      endcase
      cand = (t_idx < t_len) && (win_trig(t_st, t_k, t_n) == t_pos);
   end

   always_comb begin
      hlo = win_lo(sth_ff);
      hhi = win_hi(sth_ff, cfg.kh, cfg.eff_h);
      wlo = win_lo(stw_ff);
      whi = win_hi(stw_ff, cfg.kw, cfg.eff_w);
      win_empty    = (hhi <= hlo) || (whi <= wlo);
      scan_row_end = ({6'b0, x_ff} == whi - pos_type'(1));
      scan_end     = scan_row_end && ({6'b0, y_ff} == hhi - pos_type'(1));
      row_end      = ({1'b0, c_ff} == cfg.eff_w - 9'd1);
      plane_end    = ({1'b0, r_ff} == cfg.eff_h - 9'd1);
      new_pl       = (ph_ff == cfg.out_h - 9'd1) && (pw_ff == cfg.out_w - 9'd1);
   end

   // outputs of the sequencer
   always_comb begin
      req_stall = cfg.busy || (state_ff != ST_IDLE);
      accept    = req_valid && !req_stall;
      slot_free = !out_vld_ff || !rsp_stall;
      wr_en     = accept;
      wr_addr   = {r_ff[KROW_BITS-1:0], c_ff[COL_BITS-1:0]};
      rd_en     = (state_ff == ST_SCAN);
      rd_addr   = {y_ff[KROW_BITS-1:0], x_ff[COL_BITS-1:0]};
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (accept) state_in = ST_ROW;
         ST_ROW:   state_in = cand ? ST_COL : ST_FLUSH;
         ST_COL: begin
            if (cnt_ff == 7'(MAX_RESULTS)) state_in = ST_FLUSH;
            else if (!cand)                state_in = ST_ROW;
            else if (win_empty)            state_in = ST_EMIT;
            else                           state_in = ST_SCAN;
         end
         ST_SCAN:  if (scan_end) state_in = ST_DRAIN;
         ST_DRAIN: state_in = ST_EMIT;
         ST_EMIT:  if (!pend_ff || slot_free) state_in = ST_COL;
         ST_FLUSH: if (!pend_ff || slot_free) state_in = ST_ADVW;
         ST_ADVW:  if (!cand) state_in = row_end ? ST_ADVH : ST_NEXT;
         ST_ADVH:  if (!cand) state_in = ST_NEXT;
         ST_NEXT:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         out_vld_ff <= 1'b0;
         pend_ff    <= 1'b0;
         rd_vld_ff  <= 1'b0;
         r_ff <= '0; c_ff <= '0;
         ph_base_ff <= '0; pw_base_ff <= '0;
         sth_base_ff <= '0; stw_base_ff <= '0;
         cnt_ff <= '0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= rd_en;
         if (out_vld_ff && !rsp_stall) out_vld_ff <= 1'b0;
         if (cfg.busy) begin
            // restart the plane at its first pixel
            r_ff <= '0; c_ff <= '0;
            ph_base_ff <= '0; pw_base_ff <= '0;
            sth_base_ff <= -$signed({11'b0, cfg.ph});
            stw_base_ff <= -$signed({11'b0, cfg.pw});
         end
         if (rd_vld_ff && (rd_data > best_ff)) best_ff <= rd_data;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  fin_ff <= req_final_sample;
                  ph_ff  <= ph_base_ff;
                  sth_ff <= sth_base_ff;
                  cnt_ff <= '0;
               end
            end
            ST_ROW: begin
               pw_ff  <= pw_base_ff;
               stw_ff <= stw_base_ff;
            end
            ST_COL: begin
               best_ff <= SAMPLE_MIN;
               y_ff    <= hlo[7:0];
               x_ff    <= wlo[7:0];
               if (!cand) begin
                  ph_ff  <= ph_ff + 9'd1;
                  sth_ff <= sth_ff + $signed({10'b0, cfg.sh});
               end
            end
            ST_SCAN: begin
               if (scan_row_end) begin
                  x_ff <= wlo[7:0];
                  y_ff <= y_ff + 8'd1;
               end else begin
                  x_ff <= x_ff + 8'd1;
               end
            end
            ST_EMIT: begin
               if (!pend_ff || slot_free) begin
                  // hand the held result on, hold the new one
                  if (pend_ff) begin
                     out_vld_ff  <= 1'b1;
                     out_val_ff  <= pend_val_ff;
                     out_row_ff  <= pend_row_ff;
                     out_col_ff  <= pend_col_ff;
                     out_pl_ff   <= pend_pl_ff;
                     out_tl_ff   <= pend_tl_ff;
                     out_last_ff <= 1'b0;
                  end
                  pend_ff     <= 1'b1;
                  pend_val_ff <= best_ff;
                  pend_row_ff <= ph_ff;
                  pend_col_ff <= pw_ff;
                  pend_pl_ff  <= new_pl;
                  pend_tl_ff  <= new_pl && fin_ff;
                  pw_ff  <= pw_ff + 9'd1;
                  stw_ff <= stw_ff + $signed({10'b0, cfg.sw});
                  cnt_ff <= cnt_ff + 7'd1;
               end
            end
            ST_FLUSH: begin
               if (pend_ff && slot_free) begin
                  out_vld_ff  <= 1'b1;
                  out_val_ff  <= pend_val_ff;
                  out_row_ff  <= pend_row_ff;
                  out_col_ff  <= pend_col_ff;
                  out_pl_ff   <= pend_pl_ff;
                  out_tl_ff   <= pend_tl_ff;
                  out_last_ff <= 1'b1;
                  pend_ff     <= 1'b0;
               end
            end
            ST_ADVW: begin
               if (cand) begin
                  pw_base_ff  <= pw_base_ff + 9'd1;
                  stw_base_ff <= stw_base_ff + $signed({10'b0, cfg.sw});
               end
            end
            ST_ADVH: begin
               if (cand) begin
                  ph_base_ff  <= ph_base_ff + 9'd1;
                  sth_base_ff <= sth_base_ff + $signed({10'b0, cfg.sh});
               end
            end
            ST_NEXT: begin
               if (row_end || fin_ff) begin
                  c_ff <= '0;
                  pw_base_ff  <= '0;
                  stw_base_ff <= -$signed({11'b0, cfg.pw});
                  if (plane_end || fin_ff) begin
                     r_ff <= '0;
                     ph_base_ff  <= '0;
                     sth_base_ff <= -$signed({11'b0, cfg.ph});
                  end else begin
                     r_ff <= r_ff + 8'd1;
                  end
               end else begin
                  c_ff <= c_ff + 8'd1;
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_pooled_value = out_val_ff;
   assign rsp_pooled_row   = out_row_ff;
   assign rsp_pooled_col   = out_col_ff;
   assign rsp_run_last     = out_last_ff;
   assign rsp_plane_last   = out_pl_ff;
   assign rsp_tensor_last  = out_tl_ff;

   `MP2D_ASSERT(a_cnt_cap, cnt_ff <= 7'(MAX_RESULTS), "result count past cap")
   `MP2D_ASSERT(a_rd_from_scan, rd_vld_ff |-> $past(state_ff == ST_SCAN), "stray read data")
   `MP2D_ASSERT(a_busy_idle, cfg.busy |-> state_ff == ST_IDLE, "resize while busy")
   `MP2D_ASSERT(a_pend_clear, state_ff == ST_NEXT |-> !pend_ff, "held result left behind")

endmodule

// File: dv/max_pooling_2d_window_top_tb.sv
// ---------------------------------------------------------------------------
// Max pooling window - testbench
// Streams pixels through the pooling block under several window, stride and
// border settings. Every pooled window is predicted in the bench and checked
// in arrival order. Idle and stall pressure varies from phase to phase.
// ---------------------------------------------------------------------------
module max_pooling_2d_window_top_tb import mp2d_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 4000000;
   localparam int SETTLE      = 700;   // resize pass plus one slow pixel walk

   typedef struct {
      logic signed [SAMPLE_BITS-1:0] value;
      logic [8:0]                    row;
      logic [8:0]                    col;
      logic                          run_last;
      logic                          plane_last;
      logic                          tensor_last;
   } pooled_type;

   typedef struct {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          fin;
   } pixel_type;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic signed [SAMPLE_BITS-1:0] req_sample;
   logic                          req_final_sample;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic signed [SAMPLE_BITS-1:0] rsp_pooled_value;
   logic [8:0]                    rsp_pooled_row;
   logic [8:0]                    rsp_pooled_col;
   logic                          rsp_run_last;
   logic                          rsp_plane_last;
   logic                          rsp_tensor_last;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [3:0]                    csr_index;
   logic [8:0]                    csr_wdata;

   max_pooling_2d_window_top u_dut (.*);

   // pending pixels and predicted windows
   pixel_type  pixel_q[$];
   pooled_type window_q[$];
   logic       req_taken;
   int         err_cnt;
   int         cycle_cnt;
   int         send_idle;
   int         recv_stall;

   // predictor state
   int                            reg_val[8];
   int                            eh, ew, ekh, ekw, esh, esw, eph, epw;
   int                            pool_h, pool_w;
   int                            pix_row, pix_col;
   logic signed [SAMPLE_BITS-1:0] line_buf[STORE_DEPTH];

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic report_err(input string msg);
      $display("mismatch: %s", msg);
      err_cnt++;
   endtask

   function automatic int clip(input int v, input int lo, input int hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic int pooled_len(input int n, input int k, input int s, input int p,
                                     input bit anypad);
      int num;
      int q;
      int len;
      num = n + 2 * p - k;
      q   = num >= 0 ? (num + s - 1) / s : -((-num) / s);
      len = q + 1;
      if (len > 0 && anypad && (len - 1) * s >= n + p) len--;
      return len > 0 ? len : 0;
   endfunction

   // clipped span [lo, hi) of one window along a dimension; returns trigger
   function automatic int win_span(input int idx, input int s, input int p, input int k,
                                   input int n, output int lo, output int hi);
      int st;
      int en;
      st = idx * s - p;
      en = st + k;
      if (en > n) en = n;
      lo = st < 0 ? 0 : st;
      hi = en;
      return clip(en - 1, 0, n - 1);
   endfunction

   function automatic void resize_plane();
      bit anypad;
      eh  = clip(reg_val[REG_IMAGE_HEIGHT], 1, MAX_HEIGHT);
      ew  = clip(reg_val[REG_IMAGE_WIDTH], 1, MAX_WIDTH);
      ekh = clip(reg_val[REG_WINDOW_HEIGHT], 1, MAX_KERNEL);
      ekw = clip(reg_val[REG_WINDOW_WIDTH], 1, MAX_KERNEL);
      esh = reg_val[REG_STEP_ROWS] == 0 ? 1 : reg_val[REG_STEP_ROWS];
      esw = reg_val[REG_STEP_COLS] == 0 ? 1 : reg_val[REG_STEP_COLS];
      eph = reg_val[REG_BORDER_ROWS];
      epw = reg_val[REG_BORDER_COLS];
      anypad = eph != 0 || epw != 0;
      pool_h = pooled_len(eh, ekh, esh, eph, anypad);
      pool_w = pooled_len(ew, ekw, esw, epw, anypad);
      if (pool_h > MAX_HEIGHT + 16) pool_h = MAX_HEIGHT + 16;
      if (pool_w > MAX_WIDTH + 16) pool_w = MAX_WIDTH + 16;
      pix_row = 0;
      pix_col = 0;
   endfunction

   // store one pixel and queue each window it completes, up to MAX_RESULTS
   function automatic void pool_predict(input logic signed [SAMPLE_BITS-1:0] smp,
                                        input logic fin);
      int         rows[$];
      int         cols[$];
      pooled_type found[$];
      pooled_type w;
      int         lo, hi, hlo, hhi, wlo, whi;
      logic signed [SAMPLE_BITS-1:0] best;
      logic signed [SAMPLE_BITS-1:0] s;
      line_buf[(pix_row % MAX_KERNEL) * MAX_WIDTH + pix_col] = smp;
      for (int i = 0; i < pool_h; i++)
         if (win_span(i, esh, eph, ekh, eh, lo, hi) == pix_row) rows.push_back(i);
      if (rows.size() > 0)
         for (int j = 0; j < pool_w; j++)
            if (win_span(j, esw, epw, ekw, ew, lo, hi) == pix_col) cols.push_back(j);
      foreach (rows[i]) begin
         void'(win_span(rows[i], esh, eph, ekh, eh, hlo, hhi));
         foreach (cols[j]) begin
            if (found.size() < MAX_RESULTS) begin
               void'(win_span(cols[j], esw, epw, ekw, ew, wlo, whi));
               best = SAMPLE_MIN;
               for (int y = hlo; y < hhi; y++)
                  for (int x = wlo; x < whi; x++) begin
                     s = line_buf[(y % MAX_KERNEL) * MAX_WIDTH + x];
                     if (s > best) best = s;
                  end
               w.value       = best;
               w.row         = 9'(rows[i]);
               w.col         = 9'(cols[j]);
               w.run_last    = 1'b0;
               w.plane_last  = rows[i] == pool_h - 1 && cols[j] == pool_w - 1;
               w.tensor_last = w.plane_last && fin;
               found.push_back(w);
            end
         end
      end
      if (found.size() > 0) found[found.size() - 1].run_last = 1'b1;
      foreach (found[k]) window_q.push_back(found[k]);
      // advance the raster position
      pix_col++;
      if (pix_col >= ew) begin
         pix_col = 0;
         pix_row++;
         if (pix_row >= eh) pix_row = 0;
      end
      if (fin) begin
         pix_row = 0;
         pix_col = 0;
      end
   endfunction

   // drive requests and response stall at the falling edge
   always @(negedge clock) begin
      if (!reset) begin
         if (!(req_valid && !req_taken)) begin
            if (pixel_q.size() > 0 && $urandom_range(99) >= send_idle) begin
               req_valid        <= 1'b1;
               req_sample       <= pixel_q[0].sample;
               req_final_sample <= pixel_q[0].fin;
               void'(pixel_q.pop_front());
            end else begin
               req_valid <= 1'b0;   // hold payload, drop valid
            end
         end
         rsp_stall <= $urandom_range(99) < recv_stall;
      end
   end

   // predict accepted requests and check accepted results
   always @(posedge clock) begin
      pooled_type e;
      req_taken <= req_valid && !req_stall && !reset;
      if (!reset) begin
         cycle_cnt++;
         if (req_valid && !req_stall) pool_predict(req_sample, req_final_sample);
         if (rsp_valid && !rsp_stall) begin
            if (window_q.size() == 0) begin
               report_err($sformatf("unexpected window (%0d,%0d) value %0d",
                                    rsp_pooled_row, rsp_pooled_col, rsp_pooled_value));
            end else begin
               e = window_q.pop_front();
               if (rsp_pooled_value !== e.value || rsp_pooled_row !== e.row ||
                   rsp_pooled_col !== e.col || rsp_run_last !== e.run_last ||
                   rsp_plane_last !== e.plane_last || rsp_tensor_last !== e.tensor_last)
                  report_err($sformatf(
                     "got v%0d r%0d c%0d l%b%b%b, want v%0d r%0d c%0d l%b%b%b",
                     rsp_pooled_value, rsp_pooled_row, rsp_pooled_col, rsp_run_last,
                     rsp_plane_last, rsp_tensor_last, e.value, e.row, e.col,
                     e.run_last, e.plane_last, e.tensor_last));
            end
         end
         if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("[max_pooling_2d_window_top] ERROR");
            $finish;
         end
      end
   end

   // wait until every request is taken and every window has come back
   task automatic drain();
      while (pixel_q.size() > 0 || req_valid || window_q.size() > 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [3:0] idx, input int val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= 9'(val);
      do @(posedge clock); while (!csr_ready);
      case (idx) inside
         REG_WINDOW_HEIGHT, REG_WINDOW_WIDTH,
         REG_STEP_ROWS, REG_STEP_COLS: reg_val[idx] = val & 15;
         REG_BORDER_ROWS, REG_BORDER_COLS: reg_val[idx] = val & 7;
         default: reg_val[idx] = val & 511;
      endcase
      resize_plane();
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_plane(input int h, input int w, input int kh, input int kw,
                            input int sr, input int sc, input int br, input int bc);
      drain();
      repeat (SETTLE) @(posedge clock);
      csr_write(REG_IMAGE_HEIGHT, h);
      csr_write(REG_IMAGE_WIDTH, w);
      csr_write(REG_WINDOW_HEIGHT, kh);
      csr_write(REG_WINDOW_WIDTH, kw);
      csr_write(REG_STEP_ROWS, sr);
      csr_write(REG_STEP_COLS, sc);
      csr_write(REG_BORDER_ROWS, br);
      csr_write(REG_BORDER_COLS, bc);
   endtask

   function automatic void push_pixel(input int v, input bit fin);
      pixel_type p;
      p.sample = SAMPLE_BITS'(v);
      p.fin    = fin;
      pixel_q.push_back(p);
   endfunction

   function automatic void push_random(input int n);
      int v;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(7))
            0:       v = 32767;
            1:       v = -32768;
            2:       v = $urandom_range(15) - 8;
            default: v = $urandom_range(65535);
         endcase
         push_pixel(v, $urandom_range(39) == 0);
      end
   endfunction

   task automatic set_idle(input int phase);
      case (phase % 4)
         0: begin send_idle = 0;  recv_stall = 0;  end
         1: begin send_idle = 64; recv_stall = 0;  end
         2: begin send_idle = 0;  recv_stall = 64; end
         default: begin send_idle = 22; recv_stall = 22; end
      endcase
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_sample       = '0;
      req_final_sample = 1'b0;
      rsp_stall        = 1'b0;
      csr_valid        = 1'b0;
      csr_index        = REG_IMAGE_HEIGHT;
      csr_wdata        = '0;
      req_taken        = 1'b0;
      err_cnt          = 0;
      cycle_cnt        = 0;
      send_idle        = 0;
      recv_stall       = 0;
      reg_val          = '{8, 8, 2, 2, 2, 2, 0, 0};
      resize_plane();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: reset plane with field extremes, then an early tensor end
      push_pixel(32767, 0);  push_pixel(-32768, 0); push_pixel(0, 0);  push_pixel(-1, 0);
      for (int i = 0; i < 12; i++) push_pixel(i % 2 ? -32768 : 32767, 0);
      push_pixel(5, 0); push_pixel(-5, 1);
      push_pixel(1, 0); push_pixel(2, 0); push_pixel(3, 0);
      drain();   // sender holds off until every window is back
      push_random(15);

      // borders with overlapping windows
      set_plane(4, 5, 3, 3, 1, 1, 1, 1);
      set_idle(1);
      push_random(20);

      // windows mostly in padding; the last pixel reaches the per-pixel result cap
      set_plane(3, 3, 8, 8, 1, 1, 7, 7);
      set_idle(2);
      push_random(20);

      // smallest plane
      set_plane(1, 1, 1, 1, 1, 1, 0, 0);
      set_idle(3);
      push_random(10);

      // out-of-range values saturate
      set_plane(0, 0, 0, 0, 0, 0, 0, 0);
      set_idle(0);
      push_random(10);

      // empty pooled plane: no results at all
      set_plane(2, 511, 15, 9, 0, 8, 0, 3);
      set_idle(1);
      push_random(15);

      // wide plane
      set_plane(1, 256, 1, 8, 1, 8, 0, 0);
      set_idle(2);
      push_random(60);

      // random small settings
      for (int ph = 0; ph < 4; ph++) begin
         set_plane($urandom_range(6, 1), $urandom_range(6, 1), $urandom_range(8, 1),
                   $urandom_range(8, 1), $urandom_range(8, 1), $urandom_range(8, 1),
                   $urandom_range(7), $urandom_range(7));
         set_idle(ph);
         push_random(20);
      end

      drain();
      repeat (SETTLE) @(posedge clock);
      if (err_cnt == 0 && window_q.size() == 0) begin
         $display("[max_pooling_2d_window_top] OK");
      end else begin
         $display("[max_pooling_2d_window_top] ERROR");
      end
      $finish;
   end

endmodule
